FILE: hdl/mcrf_pkg.sv
package mcrf_pkg;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;
  localparam int LOST_W   = 32;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: hdl/multi_channel_ring_fifo_top.sv
// channel    | direction | payload
// s_axis     | in        | tdata: command, queue_sel, write_data
// m_axis     | out       | tdata: status, read_data, fill_level, lost_count
//
// one transaction per cycle in and out while m_tready takes results, one result per request
// result is registered and appears in the cycle after acceptance, read data straight from the word ram port
// the word ram is written or read at most once per request through its single port
// rst clears pointers, fill counts and lost counters; word ram contents are not cleared
// a stalled result holds the input off until m_tready takes it
module multi_channel_ring_fifo_top
  import mcrf_pkg::*;
#(
  parameter int NUM_FIFOS  = 4,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // command[1:0], queue_sel[4:2], write_data[36:5], zero fill above
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status[1:0], read_data[33:2], fill_level[38:34], lost_count[70:39], zero fill above
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W     = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_FIFOS * FIFO_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [PTR_W-1:0]  head     [NUM_FIFOS];
  logic [PTR_W-1:0]  tail     [NUM_FIFOS];
  logic [CNT_W-1:0]  count    [NUM_FIFOS];
  logic [LOST_W-1:0] lost     [NUM_FIFOS];

  cmd_t               cmd;
  logic [INDEX_W-1:0] queue_sel;
  logic [DATA_W-1:0]  write_data;
  logic               idx_ok;
  logic [IDX_W-1:0]   idx;
  logic               accept;

  logic [PTR_W-1:0]  cur_head;
  logic [PTR_W-1:0]  cur_tail;
  logic [CNT_W-1:0]  cur_count;
  logic [LOST_W-1:0] cur_lost;

  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;
  logic [CNT_W-1:0]  count_next;
  logic [LOST_W-1:0] lost_next;
  status_t           status_next;
  logic              rd_ok_next;

  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_rdata;

  status_t           status;
  logic              rd_ok;
  logic [FILL_W-1:0] fill;
  logic [LOST_W-1:0] lost_out;

  assign cmd        = cmd_t'(s_tdata[CMD_W-1:0]);
  assign queue_sel  = s_tdata[CMD_W +: INDEX_W];
  assign write_data = s_tdata[CMD_W+INDEX_W +: DATA_W];
  assign idx_ok     = 32'(queue_sel) < NUM_FIFOS;
  assign idx        = IDX_W'(queue_sel);
  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;

  always_comb begin
    cur_head  = '0;
    cur_tail  = '0;
    cur_count = '0;
    cur_lost  = '0;
    if (idx_ok) begin
      cur_head  = head[idx];
      cur_tail  = tail[idx];
      cur_count = count[idx];
      cur_lost  = lost[idx];
    end
  end

  always_comb begin
    head_next   = cur_head;
    tail_next   = cur_tail;
    count_next  = cur_count;
    lost_next   = cur_lost;
    status_next = ST_OK;
    rd_ok_next  = 1'b0;
    mem_ctl     = '0;
    mem_addr    = ADDR_W'(32'(idx) * FIFO_DEPTH);
    unique case (cmd)
      CMD_INIT: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
        lost_next  = '0;
      end
      CMD_READ: begin
        if (cur_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          rd_ok_next    = 1'b1;
          mem_ctl.rd_en = accept && idx_ok;
          mem_addr      = mem_addr + ADDR_W'(cur_head);
          head_next     = (cur_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : cur_head + 1'b1;
          count_next    = cur_count - 1'b1;
        end
      end
      CMD_WRITE: begin
        if (cur_count == CNT_W'(FIFO_DEPTH)) begin
          status_next = ST_FULL;
          lost_next   = cur_lost + 1'b1;
        end else begin
          mem_ctl.wr_en = accept && idx_ok;
          mem_addr      = mem_addr + ADDR_W'(cur_tail);
          tail_next     = (cur_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
          count_next    = cur_count + 1'b1;
        end
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
    if (!idx_ok) begin
      status_next = ST_BAD_INDEX;
      rd_ok_next  = 1'b0;
      count_next  = '0;
      lost_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FIFOS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
        lost[i]  <= '0;
      end
    end else if (accept && idx_ok) begin
      head[idx]  <= head_next;
      tail[idx]  <= tail_next;
      count[idx] <= count_next;
      lost[idx]  <= lost_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      rd_ok    <= rd_ok_next;
      fill     <= FILL_W'(count_next);
      lost_out <= lost_next;
    end
  end

  mcrf_word_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_word_ram (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (write_data),
    .rdata (mem_rdata)
  );

  assign m_tdata = {1'b0, lost_out, fill, (rd_ok ? mem_rdata : '0), status};

endmodule

FILE: hdl/mcrf_word_ram.sv
module mcrf_word_ram
  import mcrf_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mcrf_pkg::*;

  localparam int NUM_FIFOS  = 4;
  localparam int FIFO_DEPTH = 16;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] read_data;
    logic [FILL_W-1:0] fill_level;
    logic [LOST_W-1:0] lost_count;
  } response_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  // shadow copy of the fifo bank
  logic [DATA_W-1:0] shadow_words [NUM_FIFOS][FIFO_DEPTH];
  int unsigned       shadow_head  [NUM_FIFOS];
  int unsigned       shadow_tail  [NUM_FIFOS];
  int unsigned       shadow_fill  [NUM_FIFOS];
  logic [LOST_W-1:0] shadow_lost  [NUM_FIFOS];

  response_t pending_responses [$];
  response_t want;
  int        mismatch_count = 0;
  bit        no_idle = 1'b0;

  multi_channel_ring_fifo_top #(
    .NUM_FIFOS (NUM_FIFOS),
    .FIFO_DEPTH(FIFO_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int idle_cycles();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic response_t apply_request(cmd_t cmd, logic [INDEX_W-1:0] idx,
                                              logic [DATA_W-1:0] data);
    response_t r;
    r.status     = ST_OK;
    r.read_data  = '0;
    r.fill_level = '0;
    r.lost_count = '0;
    if (idx >= NUM_FIFOS) begin
      r.status = ST_BAD_INDEX;
      return r;
    end
    case (cmd)
      CMD_INIT: begin
        shadow_head[idx] = 0;
        shadow_tail[idx] = 0;
        shadow_fill[idx] = 0;
        shadow_lost[idx] = '0;
      end
      CMD_READ: begin
        if (shadow_fill[idx] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_data = shadow_words[idx][shadow_head[idx]];
          shadow_head[idx] = (shadow_head[idx] + 1) % FIFO_DEPTH;
          shadow_fill[idx]--;
        end
      end
      CMD_WRITE: begin
        if (shadow_fill[idx] >= FIFO_DEPTH) begin
          shadow_lost[idx] = shadow_lost[idx] + 1'b1;
          r.status = ST_FULL;
        end else begin
          shadow_words[idx][shadow_tail[idx]] = data;
          shadow_tail[idx] = (shadow_tail[idx] + 1) % FIFO_DEPTH;
          shadow_fill[idx]++;
        end
      end
      default: begin
      end
    endcase
    r.fill_level = FILL_W'(shadow_fill[idx]);
    r.lost_count = shadow_lost[idx];
    return r;
  endfunction

  task automatic send_request(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, data, idx, cmd};
    do @(posedge clk); while (!s_tready);
    pending_responses.push_back(apply_request(cmd, idx, data));
  endtask

  // result side backpressure
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = idle_cycles();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  function automatic void check_field(string name, logic [31:0] expected_value,
                                      logic [31:0] actual_value);
    if (expected_value !== actual_value) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected_value,
               actual_value);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
        check_field("read_data", want.read_data, m_tdata[33:2]);
        check_field("fill_level", 32'(want.fill_level), 32'(m_tdata[38:34]));
        check_field("lost_count", want.lost_count, m_tdata[70:39]);
      end
    end
  end

  task automatic test_fill_and_overflow();
    logic [DATA_W-1:0] pattern;
    send_request(CMD_INIT, 3'd3, 32'h0);
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      case (i)
        0: pattern = 32'h0000_0000;
        1: pattern = 32'hFFFF_FFFF;
        2: pattern = 32'hAAAA_AAAA;
        3: pattern = 32'h5555_5555;
        default: pattern = 32'h1 << (i * 2);
      endcase
      send_request(CMD_WRITE, 3'd3, pattern);
    end
    send_request(CMD_WRITE, 3'd3, 32'hDEAD_BEEF);
    send_request(CMD_WRITE, 3'd3, 32'h1234_5678);
    send_request(CMD_READ, 3'd3, 32'hFFFF_FFFF);
  endtask

  task automatic test_special_cases();
    send_request(CMD_NOP, 3'd3, 32'h0);
    send_request(CMD_READ, 3'd2, 32'h0);
    send_request(CMD_WRITE, 3'd4, 32'hFFFF_FFFF);
    send_request(CMD_READ, 3'd7, 32'h0);
    send_request(CMD_NOP, 3'd5, 32'h0);
    send_request(CMD_INIT, 3'd6, 32'h0);
    send_request(CMD_INIT, 3'd3, 32'h0);
  endtask

  task automatic test_random_traffic();
    int   roll;
    int   write_share;
    int   focus;
    bit   focused;
    cmd_t cmd;
    logic [INDEX_W-1:0] idx;
    for (int phase = 0; phase < 19; phase++) begin
      no_idle     = (phase % 4 == 1);
      write_share = (phase % 3 == 0) ? 75 : (phase % 3 == 1) ? 46 : 20;
      focus       = $urandom_range(0, NUM_FIFOS - 1);
      focused     = $urandom_range(0, 1);
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) cmd = CMD_INIT;
        else if (roll < 7) cmd = CMD_NOP;
        else if (roll < 7 + write_share) cmd = CMD_WRITE;
        else cmd = CMD_READ;
        if ($urandom_range(0, 99) < 8) idx = INDEX_W'($urandom_range(NUM_FIFOS, 7));
        else if (focused && $urandom_range(0, 3) != 0) idx = INDEX_W'(focus);
        else idx = INDEX_W'($urandom_range(0, NUM_FIFOS - 1));
        send_request(cmd, idx, $urandom());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    // shadow state matches the cleared bank after reset
    for (int i = 0; i < NUM_FIFOS; i++) begin
      shadow_head[i] = 0;
      shadow_tail[i] = 0;
      shadow_fill[i] = 0;
      shadow_lost[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_fill_and_overflow();
    test_special_cases();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
